>>> design/keyed_table_insert_delete_search_defines.svh
// Assertion macros shared by the keyed table modules.
// Depends on nothing; users must have clk and arst_n in scope.

`ifndef KEYED_TABLE_INSERT_DELETE_SEARCH_DEFINES_SVH
`define KEYED_TABLE_INSERT_DELETE_SEARCH_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Checked at every clock edge once reset has been released.
`define KT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define KT_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define KT_ASSERT(label, prop, msg)
`define KT_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

>>> design/kt_pkg.sv
// Shared constants, codes and control types of the keyed table.
// Depends on nothing.

package kt_pkg;

	localparam int ENTRIES     = 16;
	localparam int KEY_BITS    = 64;
	localparam int VALUE_BITS  = 64;

	localparam int FIELD_BITS  = 64;
	localparam int OPCODE_BITS = 2;
	localparam int STATUS_BITS = 2;
	localparam int COUNT_BITS  = 5;

	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef enum logic [OPCODE_BITS-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_SEARCH = 2'd2,
		OP_UPDATE = 2'd3
	} kt_op_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_DONE = 2'd0,
		ST_FULL = 2'd1,
		ST_MISS = 2'd2
	} kt_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SH_RD,
		S_SH_WR,
		S_FINISH
	} kt_state_t;

	typedef enum logic {
		RD_CUR,
		RD_NEXT
	} kt_rd_sel_t;

	typedef enum logic [1:0] {
		WR_APPEND,
		WR_REPLACE,
		WR_SHIFT
	} kt_wr_sel_t;

	typedef struct packed {
		logic       load;
		logic       idx_inc;
		logic       rd_en;
		kt_rd_sel_t rd_sel;
		logic       wr_en;
		kt_wr_sel_t wr_sel;
		logic       fill_inc;
		logic       fill_dec;
		logic       stat_wr;
		kt_status_t stat_code;
		logic       found_cap;
		logic       res_load;
	} kt_cmd_t;

	typedef struct packed {
		kt_op_t op;
		logic   full;
		logic   scan_end;
		logic   match;
		logic   shift_end;
	} kt_sts_t;

endpackage

>>> design/kt_if.sv
// Valid/ready channel interfaces for the request and response items.
// Depends on kt_pkg.

interface kt_req_if import kt_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [OPCODE_BITS-1:0] opcode;
	logic [FIELD_BITS-1:0]  lookup_key;
	logic [FIELD_BITS-1:0]  new_key;
	logic [FIELD_BITS-1:0]  entry_value;

	modport source (output valid, output opcode, output lookup_key, output new_key,
		output entry_value, input ready);
	modport sink (input valid, input opcode, input lookup_key, input new_key,
		input entry_value, output ready);
endinterface

interface kt_rsp_if import kt_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [STATUS_BITS-1:0] status;
	logic [FIELD_BITS-1:0]  found_value;
	logic [COUNT_BITS-1:0]  entry_count;

	modport source (output valid, output status, output found_value, output entry_count,
		input ready);
	modport sink (input valid, input status, input found_value, input entry_count,
		output ready);
endinterface

>>> design/kt_datapath.sv
// Datapath of the keyed table: key and value stores, fill count, scan index,
// match compare and result registers. Depends on kt_pkg and the defines header.

`include "keyed_table_insert_delete_search_defines.svh"

module kt_datapath import kt_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  kt_cmd_t                cmd,
	output kt_sts_t                sts,
	input  logic [OPCODE_BITS-1:0] opcode,
	input  logic [FIELD_BITS-1:0]  lookup_key,
	input  logic [FIELD_BITS-1:0]  new_key,
	input  logic [FIELD_BITS-1:0]  entry_value,
	output logic [STATUS_BITS-1:0] status,
	output logic [FIELD_BITS-1:0]  found_value,
	output logic [COUNT_BITS-1:0]  entry_count
);

	logic [KEY_BITS-1:0]   key_mem [ENTRIES];
	logic [VALUE_BITS-1:0] val_mem [ENTRIES];

	kt_op_t                op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [KEY_BITS-1:0]   nkey_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [KEY_BITS-1:0]   rd_key_q;
	logic [VALUE_BITS-1:0] rd_val_q;

	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] next_idx;
	logic [CNT_W-1:0] rd_pos;
	logic [CNT_W-1:0] wr_pos;
	logic [KEY_BITS-1:0]   wr_key;
	logic [VALUE_BITS-1:0] wr_val;

	kt_status_t            pend_status_q;
	logic [VALUE_BITS-1:0] pend_found_q;
	kt_status_t            res_status_q;
	logic [VALUE_BITS-1:0] res_found_q;
	logic [CNT_W-1:0]      res_count_q;

	assign next_idx = idx_q + CNT_W'(1);
	assign rd_pos   = (cmd.rd_sel == RD_NEXT) ? next_idx : idx_q;

	always_comb begin
		case (cmd.wr_sel)
			WR_APPEND: begin
				wr_pos = fill_q;
				wr_key = key_q;
				wr_val = val_q;
			end
			WR_REPLACE: begin
				wr_pos = idx_q;
				wr_key = nkey_q;
				wr_val = val_q;
			end
			WR_SHIFT: begin
				wr_pos = idx_q;
				wr_key = rd_key_q;
				wr_val = rd_val_q;
			end
			default: begin
				wr_pos = idx_q;
				wr_key = rd_key_q;
				wr_val = rd_val_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			key_mem[wr_pos[IDX_W-1:0]] <= wr_key;
			val_mem[wr_pos[IDX_W-1:0]] <= wr_val;
		end
		if (cmd.rd_en) begin
			rd_key_q <= key_mem[rd_pos[IDX_W-1:0]];
			rd_val_q <= val_mem[rd_pos[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q          <= kt_op_t'(opcode);
			key_q         <= KEY_BITS'(lookup_key);
			nkey_q        <= KEY_BITS'(new_key);
			val_q         <= VALUE_BITS'(entry_value);
			pend_status_q <= ST_DONE;
			pend_found_q  <= '0;
		end else begin
			if (cmd.stat_wr) begin
				pend_status_q <= cmd.stat_code;
			end
			if (cmd.found_cap) begin
				pend_found_q <= rd_val_q;
			end
		end
		if (cmd.res_load) begin
			res_status_q <= pend_status_q;
			res_found_q  <= pend_found_q;
			res_count_q  <= fill_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			idx_q  <= '0;
		end else begin
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= next_idx;
			end
			if (cmd.fill_inc) begin
				fill_q <= fill_q + CNT_W'(1);
			end else if (cmd.fill_dec) begin
				fill_q <= fill_q - CNT_W'(1);
			end
		end
	end

	assign sts.op        = op_q;
	assign sts.full      = (fill_q == CNT_W'(ENTRIES));
	assign sts.scan_end  = (idx_q >= fill_q);
	assign sts.match     = (rd_key_q == key_q);
	assign sts.shift_end = (next_idx >= fill_q);

	assign status      = res_status_q;
	assign found_value = FIELD_BITS'(res_found_q);
	assign entry_count = COUNT_BITS'(res_count_q);

	`KT_ASSERT(a_fill_range, fill_q <= CNT_W'(ENTRIES), "fill count above table size")
	`KT_ASSERT(a_read_in_use, cmd.rd_en |-> rd_pos < fill_q, "read outside the packed entries")
	`KT_ASSERT(a_write_in_range, cmd.wr_en |-> wr_pos <= fill_q && wr_pos < CNT_W'(ENTRIES), "write outside the table")
	`KT_ASSERT(a_dec_nonempty, cmd.fill_dec |-> fill_q != '0, "delete from an empty table")

endmodule

>>> design/kt_ctrl.sv
// Controller of the keyed table: sequences scan, shift and writes, and owns
// the channel handshakes. Depends on kt_pkg and the defines header.

`include "keyed_table_insert_delete_search_defines.svh"

module kt_ctrl import kt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  kt_sts_t sts,
	output kt_cmd_t cmd
);

	kt_state_t state_q;
	kt_state_t state_d;
	logic      out_valid_q;
	logic      slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = (sts.op == OP_INSERT) ? S_FINISH : S_SCAN_RD;
			end
			S_SCAN_RD: begin
				state_d = sts.scan_end ? S_FINISH : S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				if (sts.match) begin
					state_d = (sts.op == OP_DELETE) ? S_SH_RD : S_FINISH;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_SH_RD: begin
				state_d = sts.shift_end ? S_FINISH : S_SH_WR;
			end
			S_SH_WR: begin
				state_d = S_SH_RD;
			end
			S_FINISH: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_DECODE: begin
				if (sts.op == OP_INSERT) begin
					if (sts.full) begin
						cmd.stat_wr   = 1'b1;
						cmd.stat_code = ST_FULL;
					end else begin
						cmd.wr_en    = 1'b1;
						cmd.wr_sel   = WR_APPEND;
						cmd.fill_inc = 1'b1;
					end
				end
			end
			S_SCAN_RD: begin
				if (sts.scan_end) begin
					cmd.stat_wr   = 1'b1;
					cmd.stat_code = ST_MISS;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_CUR;
				end
			end
			S_SCAN_CMP: begin
				if (sts.match) begin
					case (sts.op)
						OP_SEARCH: begin
							cmd.found_cap = 1'b1;
						end
						OP_UPDATE: begin
							cmd.wr_en  = 1'b1;
							cmd.wr_sel = WR_REPLACE;
						end
						default: begin
						end
					endcase
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			S_SH_RD: begin
				if (sts.shift_end) begin
					cmd.fill_dec = 1'b1;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_NEXT;
				end
			end
			S_SH_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_SHIFT;
				cmd.idx_inc = 1'b1;
			end
			S_FINISH: begin
				cmd.res_load = slot_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`KT_ASSERT(a_no_overwrite, cmd.res_load |-> !out_valid_q || out_ready, "result overwritten before taken")
	`KT_ASSERT(a_accept_decodes, in_valid && in_ready |=> state_q == S_DECODE, "accepted item not decoded")
	`KT_ASSERT(a_shift_order, state_q == S_SH_WR |-> $past(state_q) == S_SH_RD, "shift write without a read")

endmodule

>>> design/keyed_table_insert_delete_search.sv
// Top level of the keyed table: joins controller and datapath to the channels.
// Depends on kt_pkg, kt_if, kt_ctrl and kt_datapath.

// A packed key/value table of ENTRIES entries, empty after reset, handling one
// request item at a time and returning exactly one response item for each.
// Insert appends the new entry after the packed entries without a scan.
// Delete, search and update scan the entries in order through the single read
// port of the stores, a read and a compare per entry, and delete then moves the
// later entries down, a read and a write per entry. A finished response waits in
// an output register, so a new item is accepted while it is still not taken.

module keyed_table_insert_delete_search import kt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	kt_req_if.sink     req,
	kt_rsp_if.source   rsp
);

	kt_cmd_t cmd;
	kt_sts_t sts;
	logic    in_ready;
	logic    out_valid;

	kt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	kt_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.opcode      (req.opcode),
		.lookup_key  (req.lookup_key),
		.new_key     (req.new_key),
		.entry_value (req.entry_value),
		.status      (rsp.status),
		.found_value (rsp.found_value),
		.entry_count (rsp.entry_count)
	);

	assign req.ready = in_ready;
	assign rsp.valid = out_valid;

endmodule
